@@ rtl/core/flog_pkg.sv @@
// Shared types, codes and the control store for the flash record log.
// No dependencies; imported by the sequencer, the datapath and the top level.
package flog_pkg;

    typedef logic [4:0] t_step;

    localparam logic [2:0] ACT_SCAN     = 3'd0;
    localparam logic [2:0] ACT_WRITE    = 3'd1;
    localparam logic [2:0] ACT_RELIABLE = 3'd2;
    localparam logic [2:0] ACT_READ     = 3'd3;
    localparam logic [2:0] ACT_CLEAR    = 3'd4;

    localparam logic [1:0] CFG_RECORD_BYTES = 2'd0;
    localparam logic [1:0] CFG_SLOTS_IN_USE = 2'd1;
    localparam logic [1:0] CFG_ERASED_BYTE  = 2'd2;

    localparam t_step S_RST_SWEEP = 5'd0;
    localparam t_step S_IDLE      = 5'd1;
    localparam t_step S_SCAN_TEST = 5'd2;
    localparam t_step S_SCAN_CMP  = 5'd3;
    localparam t_step S_SCAN_NEXT = 5'd4;
    localparam t_step S_SCAN_END  = 5'd5;
    localparam t_step S_WR_CHECK  = 5'd6;
    localparam t_step S_WR_ERASE  = 5'd7;
    localparam t_step S_WR_SWEEP  = 5'd8;
    localparam t_step S_APP_RD    = 5'd9;
    localparam t_step S_APP_WR    = 5'd10;
    localparam t_step S_RW_RD     = 5'd11;
    localparam t_step S_RW_CMP    = 5'd12;
    localparam t_step S_RES_RD    = 5'd13;
    localparam t_step S_RES_EMIT  = 5'd14;
    localparam t_step S_CLR_SETUP = 5'd15;
    localparam t_step S_CLR_SWEEP = 5'd16;
    localparam t_step S_CLR_DONE  = 5'd17;

    typedef enum logic [1:0] {
        RD_NONE   = 2'd0,
        RD_PTR    = 2'd1,
        RD_IDX    = 2'd2,
        RD_PTR_M1 = 2'd3
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_FILL  = 2'd1,
        WR_MERGE = 2'd2
    } t_wr_sel;

    typedef enum logic [1:0] {
        IDX_HOLD = 2'd0,
        IDX_CLR  = 2'd1,
        IDX_INC  = 2'd2
    } t_idx_op;

    typedef enum logic [1:0] {
        PTR_HOLD     = 2'd0,
        PTR_CLR      = 2'd1,
        PTR_INC      = 2'd2,
        PTR_LOAD_IDX = 2'd3
    } t_ptr_op;

    typedef enum logic [2:0] {
        C_NEXT         = 3'd0,
        C_ALWAYS       = 3'd1,
        C_DISPATCH     = 3'd2,
        C_SWEEP_MORE   = 3'd3,
        C_IDX_GE_SLOTS = 3'd4,
        C_SLOT_ERASED  = 3'd5,
        C_NOT_FULL     = 3'd6,
        C_DIFF_LATEST  = 3'd7
    } t_cond;

    typedef struct packed {
        t_rd_sel rd;
        t_wr_sel wr;
        t_idx_op idx_op;
        t_ptr_op ptr_op;
        logic    fill_load;
        logic    set_erased;
        logic    set_wrote;
        logic    emit;
        t_cond   cond;
        t_step   target;
    } t_uword;

    typedef struct packed {
        logic sweep_more;
        logic idx_ge_slots;
        logic slot_erased;
        logic not_full;
        logic diff_latest;
    } t_dp_status;

    typedef struct packed {
        logic [3:0] record_bytes;
        logic [8:0] slots_in_use;
        logic [7:0] erased_byte;
    } t_cfg;

    localparam t_uword UW_NOP = '{
        rd: RD_NONE, wr: WR_NONE, idx_op: IDX_HOLD, ptr_op: PTR_HOLD,
        fill_load: 1'b0, set_erased: 1'b0, set_wrote: 1'b0, emit: 1'b0,
        cond: C_NEXT, target: S_IDLE
    };

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = UW_NOP;
        case (s)
            S_RST_SWEEP: begin
                w.wr     = WR_FILL;
                w.idx_op = IDX_INC;
                w.cond   = C_SWEEP_MORE;
                w.target = S_RST_SWEEP;
            end
            S_IDLE: begin
                w.idx_op = IDX_CLR;
                w.cond   = C_DISPATCH;
                w.target = S_IDLE;
            end
            S_SCAN_TEST: begin
                w.rd     = RD_IDX;
                w.cond   = C_IDX_GE_SLOTS;
                w.target = S_SCAN_END;
            end
            S_SCAN_CMP: begin
                w.cond   = C_SLOT_ERASED;
                w.target = S_SCAN_END;
            end
            S_SCAN_NEXT: begin
                w.idx_op = IDX_INC;
                w.cond   = C_ALWAYS;
                w.target = S_SCAN_TEST;
            end
            S_SCAN_END: begin
                w.ptr_op = PTR_LOAD_IDX;
                w.cond   = C_ALWAYS;
                w.target = S_RES_RD;
            end
            S_WR_CHECK: begin
                w.cond   = C_NOT_FULL;
                w.target = S_APP_RD;
            end
            S_WR_ERASE: begin
                w.fill_load  = 1'b1;
                w.idx_op     = IDX_CLR;
                w.ptr_op     = PTR_CLR;
                w.set_erased = 1'b1;
            end
            S_WR_SWEEP: begin
                w.wr     = WR_FILL;
                w.idx_op = IDX_INC;
                w.cond   = C_SWEEP_MORE;
                w.target = S_WR_SWEEP;
            end
            S_APP_RD: begin
                w.rd = RD_PTR;
            end
            S_APP_WR: begin
                w.wr        = WR_MERGE;
                w.ptr_op    = PTR_INC;
                w.set_wrote = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = S_RES_RD;
            end
            S_RW_RD: begin
                w.rd = RD_PTR_M1;
            end
            S_RW_CMP: begin
                w.cond   = C_DIFF_LATEST;
                w.target = S_WR_CHECK;
            end
            S_RES_RD: begin
                w.rd = RD_PTR_M1;
            end
            S_RES_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            S_CLR_SETUP: begin
                w.fill_load  = 1'b1;
                w.idx_op     = IDX_CLR;
                w.ptr_op     = PTR_CLR;
                w.set_erased = 1'b1;
            end
            S_CLR_SWEEP: begin
                w.wr     = WR_FILL;
                w.idx_op = IDX_INC;
                w.cond   = C_SWEEP_MORE;
                w.target = S_CLR_SWEEP;
            end
            S_CLR_DONE: begin
                w.cond   = C_ALWAYS;
                w.target = S_RES_RD;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic t_step entry_step(input logic [2:0] action);
        t_step s;
        case (action)
            ACT_SCAN:     s = S_SCAN_TEST;
            ACT_WRITE:    s = S_WR_CHECK;
            ACT_RELIABLE: s = S_RW_RD;
            ACT_CLEAR:    s = S_CLR_SETUP;
            default:      s = S_RES_RD;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/flog_sequencer.sv @@
// Step counter and control store decode for the flash record log.
// Depends on flog_pkg for the control word, status and step codes.
module flog_sequencer
    import flog_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_action,
    input  t_dp_status i_status,
    output logic       o_busy,
    output logic       o_accept,
    output t_uword     o_uword
);

    t_step  r_pc;
    t_step  n_pc;
    t_uword uw;
    logic   cond_true;

    assign uw       = ucode(r_pc);
    assign o_uword  = uw;
    assign o_busy   = (r_pc != S_IDLE);
    assign o_accept = i_start && !o_busy;

    always_comb begin
        case (uw.cond)
            C_SWEEP_MORE:   cond_true = i_status.sweep_more;
            C_IDX_GE_SLOTS: cond_true = i_status.idx_ge_slots;
            C_SLOT_ERASED:  cond_true = i_status.slot_erased;
            C_NOT_FULL:     cond_true = i_status.not_full;
            C_DIFF_LATEST:  cond_true = i_status.diff_latest;
            C_ALWAYS:       cond_true = 1'b1;
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (uw.cond == C_DISPATCH) begin
            n_pc = o_accept ? entry_step(i_action) : r_pc;
        end else if (cond_true) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_RST_SWEEP;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

@@ rtl/core/flog_datapath.sv @@
// Slot memory, pointer, scan index, compare logic and result registers.
// Depends on flog_pkg; steered each cycle by the sequencer control word.
module flog_datapath
    import flog_pkg::*;
#(
    parameter int MAX_SLOTS        = 256,
    parameter int MAX_RECORD_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_uword      i_uword,
    input  logic        i_accept,
    input  logic [63:0] i_record_in,
    input  t_cfg        i_cfg,
    output t_dp_status  o_status,
    output logic        o_result_valid,
    output logic [63:0] o_record_out,
    output logic [8:0]  o_next_slot,
    output logic        o_area_erased,
    output logic        o_write_done
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int PW = $clog2(MAX_SLOTS + 1);
    localparam int SW = (PW > 9) ? PW : 9;
    localparam int RW = 8 * MAX_RECORD_BYTES;

    logic [RW-1:0] mem [MAX_SLOTS];

    logic [PW-1:0] r_idx, n_idx;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [RW-1:0] r_rec;
    logic [RW-1:0] r_rd;
    logic [7:0]    r_fill;
    logic          r_erased, n_erased;
    logic          r_wrote, n_wrote;

    logic          r_res_valid;
    logic [63:0]   r_res_record;
    logic [8:0]    r_res_slot;
    logic          r_res_erased;
    logic          r_res_wrote;

    logic [SW-1:0] slots_ext, eff_slots, ptr_ext, idx_ext;
    logic [3:0]    eff_bytes;
    logic [RW-1:0] mask;
    logic [RW-1:0] cfg_erased_word;
    logic [RW-1:0] fill_word;
    logic [RW-1:0] latest;
    logic [PW-1:0] ptr_m1;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [RW-1:0] wr_data;

    always_comb begin
        slots_ext = SW'(i_cfg.slots_in_use);
        if (slots_ext == '0) begin
            eff_slots = SW'(1);
        end else if (slots_ext > SW'(MAX_SLOTS)) begin
            eff_slots = SW'(MAX_SLOTS);
        end else begin
            eff_slots = slots_ext;
        end
    end

    always_comb begin
        if (i_cfg.record_bytes == 4'd0) begin
            eff_bytes = 4'd1;
        end else if (i_cfg.record_bytes > 4'(MAX_RECORD_BYTES)) begin
            eff_bytes = 4'(MAX_RECORD_BYTES);
        end else begin
            eff_bytes = i_cfg.record_bytes;
        end
    end

    always_comb begin
        for (int b = 0; b < MAX_RECORD_BYTES; b++) begin
            mask[8*b +: 8] = (4'(b) < eff_bytes) ? 8'hFF : 8'h00;
        end
    end

    assign cfg_erased_word = {MAX_RECORD_BYTES{i_cfg.erased_byte}};
    assign fill_word       = {MAX_RECORD_BYTES{r_fill}};
    assign ptr_ext         = SW'(r_ptr);
    assign idx_ext         = SW'(r_idx);
    assign ptr_m1          = r_ptr - PW'(1);
    assign latest          = (r_ptr == '0) ? '0 : (r_rd & mask);

    assign o_status.sweep_more   = (r_idx != PW'(MAX_SLOTS - 1));
    assign o_status.idx_ge_slots = (idx_ext >= eff_slots);
    assign o_status.slot_erased  = ((r_rd & mask) == (cfg_erased_word & mask));
    assign o_status.not_full     = (ptr_ext < eff_slots);
    assign o_status.diff_latest  = (latest != (r_rec & mask));

    always_comb begin
        rd_en = 1'b1;
        case (i_uword.rd)
            RD_PTR:    rd_addr = r_ptr[AW-1:0];
            RD_IDX:    rd_addr = r_idx[AW-1:0];
            RD_PTR_M1: rd_addr = ptr_m1[AW-1:0];
            default: begin
                rd_en   = 1'b0;
                rd_addr = r_ptr[AW-1:0];
            end
        endcase
    end

    always_comb begin
        case (i_uword.wr)
            WR_FILL: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                wr_data = fill_word;
            end
            WR_MERGE: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr[AW-1:0];
                wr_data = (r_rd & ~mask) | (r_rec & mask);
            end
            default: begin
                wr_en   = 1'b0;
                wr_addr = r_ptr[AW-1:0];
                wr_data = fill_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_comb begin
        case (i_uword.idx_op)
            IDX_CLR: n_idx = '0;
            IDX_INC: n_idx = r_idx + PW'(1);
            default: n_idx = r_idx;
        endcase
        case (i_uword.ptr_op)
            PTR_CLR:      n_ptr = '0;
            PTR_INC:      n_ptr = r_ptr + PW'(1);
            PTR_LOAD_IDX: n_ptr = r_idx;
            default:      n_ptr = r_ptr;
        endcase
        n_erased = r_erased;
        n_wrote  = r_wrote;
        if (i_accept) begin
            n_erased = 1'b0;
            n_wrote  = 1'b0;
        end
        if (i_uword.set_erased) begin
            n_erased = 1'b1;
        end
        if (i_uword.set_wrote) begin
            n_wrote = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_ptr       <= '0;
            r_fill      <= 8'hFF;
            r_res_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_ptr       <= n_ptr;
            r_res_valid <= i_uword.emit;
            if (i_uword.fill_load) begin
                r_fill <= i_cfg.erased_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_erased <= n_erased;
        r_wrote  <= n_wrote;
        if (i_accept) begin
            r_rec <= i_record_in[RW-1:0];
        end
        if (i_uword.emit) begin
            r_res_record <= 64'(latest);
            r_res_slot   <= ptr_ext[8:0];
            r_res_erased <= r_erased;
            r_res_wrote  <= r_wrote;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_record_out   = r_res_record;
    assign o_next_slot    = r_res_slot;
    assign o_area_erased  = r_res_erased;
    assign o_write_done   = r_res_wrote;

endmodule

@@ rtl/core/flash_record_log.sv @@
// Flash record log top: configuration registers, sequencer and datapath.
// Every action ends in a result strobe: read, write, write with erase when the store is
// full, reliable write (no append when the record matches the latest one), clear, and
// scan, which stops at the first erased slot or after the slots in use. busy falls in
// the strobe cycle, and a new start is taken only while busy is low. The slot sweep
// writes one entry a cycle. Reset clears the store with busy high.
module flash_record_log
    import flog_pkg::*;
#(
    parameter int MAX_SLOTS        = 256,
    parameter int MAX_RECORD_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [63:0] i_record_in,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    output logic        o_result_valid,
    output logic [63:0] o_record_out,
    output logic [8:0]  o_next_slot,
    output logic        o_area_erased,
    output logic        o_write_done
);

    t_cfg       r_cfg;
    t_uword     uword;
    t_dp_status status;
    logic       accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_bytes <= 4'd8;
            r_cfg.slots_in_use <= 9'd256;
            r_cfg.erased_byte  <= 8'hFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RECORD_BYTES: r_cfg.record_bytes <= i_cfg_data[3:0];
                CFG_SLOTS_IN_USE: r_cfg.slots_in_use <= i_cfg_data;
                CFG_ERASED_BYTE:  r_cfg.erased_byte  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    flog_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_status (status),
        .o_busy   (busy),
        .o_accept (accept),
        .o_uword  (uword)
    );

    flog_datapath #(
        .MAX_SLOTS        (MAX_SLOTS),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uword        (uword),
        .i_accept       (accept),
        .i_record_in    (i_record_in),
        .i_cfg          (r_cfg),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_record_out   (o_record_out),
        .o_next_slot    (o_next_slot),
        .o_area_erased  (o_area_erased),
        .o_write_done   (o_write_done)
    );

endmodule

@@ rtl/core/flog_checker.sv @@
// Port-level checks for the flash record log, attached by a bind statement.
// Depends only on the top-level ports of flash_record_log.
module flog_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       i_busy,
    input logic       i_result_valid,
    input logic [8:0] i_next_slot,
    input logic       i_area_erased,
    input logic       i_write_done
);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid |=> !i_result_valid)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> i_busy)
        else $error("busy not raised after an accepted transaction");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid |-> !i_busy)
        else $error("result strobe while busy");

    a_erase_pointer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_result_valid && i_area_erased) |-> (i_next_slot == {8'd0, i_write_done}))
        else $error("pointer after erase does not match the append flag");

endmodule

bind flash_record_log flog_checker u_flog_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (start),
    .i_busy         (busy),
    .i_result_valid (o_result_valid),
    .i_next_slot    (o_next_slot),
    .i_area_erased  (o_area_erased),
    .i_write_done   (o_write_done)
);
